// File: src/oqts_pkg.sv
// Shared types and constants for the oriented quad texture shader.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package oqts_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_QUAD = 2'd1,
    ACT_TEX  = 2'd2,
    ACT_FILL = 2'd3
  } action_t;

  typedef enum logic {
    REG_TEX_W = 1'b0,
    REG_TEX_H = 1'b1
  } reg_index_t;

  localparam int TEXEL_DEPTH_DEF = 4096;
  localparam int COORD_BITS_DEF  = 12;

  localparam int QW = 21;  // Q12.8 quad coordinate
  localparam int DW = 22;  // pixel minus origin
  localparam int EW = 24;  // edge operand differences
  localparam int PW = 45;  // products
  localparam int SW = 46;  // product sums

  typedef struct packed {
    logic        valid;
    action_t     act;
    logic [11:0] px;
    logic [11:0] py;
    logic [31:0] dest;
    logic [31:0] word;
    logic [11:0] tidx;
    logic        covered;
  } item_t;

endpackage
`default_nettype wire

// File: src/oqts_geom.sv
// Quad registers, edge functions and axis projections (four stages).
// Depends on oqts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module oqts_geom (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 en,
  input  oqts_pkg::item_t                     in_item,
  input  wire signed [oqts_pkg::QW-1:0]       origin_x,
  input  wire signed [oqts_pkg::QW-1:0]       origin_y,
  input  wire signed [oqts_pkg::QW-1:0]       xaxis_dx,
  input  wire signed [oqts_pkg::QW-1:0]       xaxis_dy,
  input  wire signed [oqts_pkg::QW-1:0]       yaxis_dx,
  input  wire signed [oqts_pkg::QW-1:0]       yaxis_dy,
  output oqts_pkg::item_t                     out_item,
  output logic signed [oqts_pkg::SW-1:0]      dot_x,
  output logic signed [oqts_pkg::SW-1:0]      dot_y,
  output logic signed [oqts_pkg::SW-1:0]      len_x,
  output logic signed [oqts_pkg::SW-1:0]      len_y
);
  localparam int QW = oqts_pkg::QW;
  localparam int DW = oqts_pkg::DW;
  localparam int EW = oqts_pkg::EW;
  localparam int PW = oqts_pkg::PW;
  localparam int SW = oqts_pkg::SW;

  logic signed [QW-1:0] qox, qoy, qax, qay, qbx, qby;

  oqts_pkg::item_t it1, it2, it3;
  logic signed [DW-1:0] dx1, dy1;
  logic signed [QW-1:0] ax1, ay1, bx1, by1;
  logic signed [EW-1:0] dx2, dy2, ex1, ey1, ex2, ey2, ex3, ey3;
  logic signed [QW-1:0] ax2, ay2, bx2, by2;
  logic signed [PW-1:0] p0a, p0b, p1a, p1b, p2a, p2b, p3a, p3b;
  logic signed [PW-1:0] d1, d2, d3, d4, l1, l2, l3, l4;
  logic signed [SW-1:0] e0, e1, e2, e3;
  logic signed [DW-1:0] dx_next, dy_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      qox <= '0; qoy <= '0; qax <= '0; qay <= '0; qbx <= '0; qby <= '0;
    end else if (en && in_item.valid && in_item.act == oqts_pkg::ACT_QUAD) begin
      qox <= origin_x; qoy <= origin_y;
      qax <= xaxis_dx; qay <= xaxis_dy;
      qbx <= yaxis_dx; qby <= yaxis_dy;
    end
  end

  always_comb begin
    dx_next = $signed({2'b00, in_item.px, 8'h00}) - DW'(qox);
    dy_next = $signed({2'b00, in_item.py, 8'h00}) - DW'(qoy);
    e0 = SW'(p0a) - SW'(p0b);
    e1 = SW'(p1a) - SW'(p1b);
    e2 = SW'(p2a) - SW'(p2b);
    e3 = SW'(p3a) - SW'(p3b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      it1.valid <= 1'b0; it2.valid <= 1'b0; it3.valid <= 1'b0; out_item.valid <= 1'b0;
    end else if (en) begin
      it1.valid <= in_item.valid;
      it2.valid <= it1.valid;
      it3.valid <= it2.valid;
      out_item.valid <= it3.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      {it1.act, it1.px, it1.py, it1.dest, it1.word, it1.tidx, it1.covered} <=
        {in_item.act, in_item.px, in_item.py, in_item.dest, in_item.word, in_item.tidx, 1'b0};
      dx1 <= dx_next; dy1 <= dy_next;
      ax1 <= qax; ay1 <= qay; bx1 <= qbx; by1 <= qby;

      {it2.act, it2.px, it2.py, it2.dest, it2.word, it2.tidx, it2.covered} <=
        {it1.act, it1.px, it1.py, it1.dest, it1.word, it1.tidx, it1.covered};
      dx2 <= EW'(dx1); dy2 <= EW'(dy1);
      ex1 <= EW'(dx1) - EW'(ax1);
      ey1 <= EW'(dy1) - EW'(ay1);
      ex2 <= EW'(dx1) - EW'(ax1) - EW'(bx1);
      ey2 <= EW'(dy1) - EW'(ay1) - EW'(by1);
      ex3 <= EW'(dx1) - EW'(bx1);
      ey3 <= EW'(dy1) - EW'(by1);
      ax2 <= ax1; ay2 <= ay1; bx2 <= bx1; by2 <= by1;

      {it3.act, it3.px, it3.py, it3.dest, it3.word, it3.tidx, it3.covered} <=
        {it2.act, it2.px, it2.py, it2.dest, it2.word, it2.tidx, it2.covered};
      p0a <= PW'(dx2) * PW'(ay2);
      p0b <= PW'(dy2) * PW'(ax2);
      p1a <= PW'(ex1) * PW'(by2);
      p1b <= PW'(ey1) * PW'(bx2);
      p2a <= PW'(ey2) * PW'(ax2);
      p2b <= PW'(ex2) * PW'(ay2);
      p3a <= PW'(ey3) * PW'(bx2);
      p3b <= PW'(ex3) * PW'(by2);
      d1 <= PW'(dx2) * PW'(ax2);
      d2 <= PW'(dy2) * PW'(ay2);
      d3 <= PW'(dx2) * PW'(bx2);
      d4 <= PW'(dy2) * PW'(by2);
      l1 <= PW'(ax2) * PW'(ax2);
      l2 <= PW'(ay2) * PW'(ay2);
      l3 <= PW'(bx2) * PW'(bx2);
      l4 <= PW'(by2) * PW'(by2);

      {out_item.act, out_item.px, out_item.py, out_item.dest, out_item.word,
       out_item.tidx} <= {it3.act, it3.px, it3.py, it3.dest, it3.word, it3.tidx};
      out_item.covered <= (e0 <= -SW'(65536)) && (e1 <= -SW'(65536)) &&
                          (e2 <= -SW'(65536)) && (e3 <= -SW'(65536));
      dot_x <= SW'(d1) + SW'(d2);
      dot_y <= SW'(d3) + SW'(d4);
      len_x <= SW'(l1) + SW'(l2);
      len_y <= SW'(l3) + SW'(l4);
    end
  end
endmodule
`default_nettype wire

// File: src/oqts_texdiv.sv
// Texel coordinate pipeline: scale, round, restoring divide one bit a stage,
// clamp and row-major index. Depends on oqts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module oqts_texdiv (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              en,
  input  oqts_pkg::item_t                  in_item,
  input  wire signed [oqts_pkg::SW-1:0]    dot_x,
  input  wire signed [oqts_pkg::SW-1:0]    dot_y,
  input  wire signed [oqts_pkg::SW-1:0]    len_x,
  input  wire signed [oqts_pkg::SW-1:0]    len_y,
  input  wire        [6:0]                 tex_w,
  input  wire        [5:0]                 tex_wm1,
  input  wire        [5:0]                 tex_hm1,
  output oqts_pkg::item_t                  out_item,
  output logic       [11:0]                tex_index
);
  localparam int SW = oqts_pkg::SW;
  localparam int NW = 53;
  localparam int TW = 55;
  localparam int RW = 54;
  localparam int NSTG = 8;

  oqts_pkg::item_t it1, it2;
  oqts_pkg::item_t itd [NSTG];

  logic signed [NW-1:0] n1   [2];
  logic        [SW:0]   dv1  [2];
  logic signed [SW-1:0] ln1  [2];
  logic                 lz1  [2];
  logic        [RW-1:0] rem  [2][NSTG+1];
  logic        [SW:0]   dvs  [2][NSTG+1];
  logic        [7:0]    q    [2][NSTG+1];
  logic                 zr   [2][NSTG+1];
  logic        [5:0]    crd  [2];
  logic signed [TW-1:0] t    [2];
  logic signed [SW-1:0] dot_in [2];
  logic signed [SW-1:0] len_in [2];
  logic        [5:0]    m1   [2];

  assign dot_in[0] = dot_x; assign dot_in[1] = dot_y;
  assign len_in[0] = len_x; assign len_in[1] = len_y;
  assign m1[0] = tex_wm1;   assign m1[1] = tex_hm1;

  always_ff @(posedge clk) begin
    if (rst) begin
      it1.valid <= 1'b0; it2.valid <= 1'b0; out_item.valid <= 1'b0;
      for (int s = 0; s < NSTG; s++) itd[s].valid <= 1'b0;
    end else if (en) begin
      it1.valid <= in_item.valid;
      it2.valid <= it1.valid;
      itd[0].valid <= it2.valid;
      for (int s = 1; s < NSTG; s++) itd[s].valid <= itd[s-1].valid;
      out_item.valid <= itd[NSTG-1].valid;
    end
    if (en) begin
      {it1.act, it1.px, it1.py, it1.dest, it1.word, it1.tidx, it1.covered} <=
        {in_item.act, in_item.px, in_item.py, in_item.dest, in_item.word, in_item.tidx,
         in_item.covered};
      {it2.act, it2.px, it2.py, it2.dest, it2.word, it2.tidx, it2.covered} <=
        {it1.act, it1.px, it1.py, it1.dest, it1.word, it1.tidx, it1.covered};
      {itd[0].act, itd[0].px, itd[0].py, itd[0].dest, itd[0].word, itd[0].tidx,
       itd[0].covered} <=
        {it2.act, it2.px, it2.py, it2.dest, it2.word, it2.tidx, it2.covered};
      for (int s = 1; s < NSTG; s++)
        {itd[s].act, itd[s].px, itd[s].py, itd[s].dest, itd[s].word, itd[s].tidx,
         itd[s].covered} <=
          {itd[s-1].act, itd[s-1].px, itd[s-1].py, itd[s-1].dest, itd[s-1].word,
           itd[s-1].tidx, itd[s-1].covered};
      {out_item.act, out_item.px, out_item.py, out_item.dest, out_item.word,
       out_item.tidx, out_item.covered} <=
        {itd[NSTG-1].act, itd[NSTG-1].px, itd[NSTG-1].py, itd[NSTG-1].dest,
         itd[NSTG-1].word, itd[NSTG-1].tidx, itd[NSTG-1].covered};
      tex_index <= 12'(crd[1]) * 12'(tex_w) + 12'(crd[0]);
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    always_comb begin
      t[l] = (TW'(n1[l]) <<< 1) + TW'(ln1[l]);
      if (zr[l][NSTG]) crd[l] = 6'd0;
      else if (q[l][NSTG] > {2'b00, m1[l]}) crd[l] = m1[l];
      else crd[l] = q[l][NSTG][5:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n1[l]  <= NW'(dot_in[l]) * NW'($signed({1'b0, m1[l]}));
        dv1[l] <= {len_in[l][SW-1:0], 1'b0};
        ln1[l] <= len_in[l];
        lz1[l] <= (len_in[l] <= '0);

        rem[l][0] <= RW'(t[l]);
        dvs[l][0] <= dv1[l];
        q[l][0]   <= 8'd0;
        zr[l][0]  <= lz1[l] || t[l][TW-1];

        for (int s = 0; s < NSTG; s++) begin
          if (rem[l][s] >= (RW'(dvs[l][s]) << (NSTG-1-s))) begin
            rem[l][s+1] <= rem[l][s] - (RW'(dvs[l][s]) << (NSTG-1-s));
            q[l][s+1]   <= q[l][s] | 8'(1 << (NSTG-1-s));
          end else begin
            rem[l][s+1] <= rem[l][s];
            q[l][s+1]   <= q[l][s];
          end
          dvs[l][s+1] <= dvs[l][s];
          zr[l][s+1]  <= zr[l][s];
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: src/oqts_shade.sv
// Texture store, alpha blend and output register.
// Depends on oqts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module oqts_shade #(
  parameter int TEXEL_DEPTH = oqts_pkg::TEXEL_DEPTH_DEF
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              en,
  input  oqts_pkg::item_t  in_item,
  input  wire  [11:0]      tex_index,
  output logic             out_valid,
  output logic [11:0]      out_x,
  output logic [11:0]      out_y,
  output logic             write_enable,
  output logic [31:0]      pixel_value
);
  localparam int AW = (TEXEL_DEPTH > 1) ? $clog2(TEXEL_DEPTH) : 1;

  logic [31:0] mem [TEXEL_DEPTH];
  logic [31:0] texel;
  logic [16:0] chan [4];
  logic [7:0]  res  [4];
  logic [16:0] v    [4];
  logic [24:0] vm   [4];
  logic [7:0]  q0   [4];
  logic [16:0] r    [4];
  oqts_pkg::item_t it1, it2;

  always_ff @(posedge clk) begin
    if (en) begin
      if (in_item.valid && in_item.act == oqts_pkg::ACT_LOAD &&
          {5'b0, in_item.tidx} < 17'(TEXEL_DEPTH))
        mem[AW'(in_item.tidx)] <= in_item.word;
      texel <= mem[AW'(tex_index)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      it1.valid <= 1'b0; it2.valid <= 1'b0; out_valid <= 1'b0;
    end else if (en) begin
      it1.valid <= in_item.valid;
      it2.valid <= it1.valid;
      out_valid <= it2.valid &&
                   (it2.act == oqts_pkg::ACT_TEX || it2.act == oqts_pkg::ACT_FILL);
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      v[c]  = chan[c] + 17'd127;
      vm[c] = 25'(v[c]) + (25'(v[c]) << 8);
      q0[c] = vm[c][23:16];
      r[c]  = v[c] - 17'(q0[c]) * 17'd255;
      res[c] = (r[c] >= 17'd255) ? q0[c] + 8'd1 : q0[c];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      {it1.act, it1.px, it1.py, it1.dest, it1.word, it1.tidx, it1.covered} <=
        {in_item.act, in_item.px, in_item.py, in_item.dest, in_item.word, in_item.tidx,
         in_item.covered};
      {it2.act, it2.px, it2.py, it2.dest, it2.word, it2.tidx, it2.covered} <=
        {it1.act, it1.px, it1.py, it1.dest, it1.word, it1.tidx, it1.covered};
      for (int c = 0; c < 4; c++)
        chan[c] <= 17'(texel[8*c +: 8]) * 17'(texel[31:24]) +
                   17'(it1.dest[8*c +: 8]) * 17'(8'd255 - texel[31:24]);
      out_x <= it2.px;
      out_y <= it2.py;
      write_enable <= it2.covered;
      if (!it2.covered) pixel_value <= it2.dest;
      else if (it2.act == oqts_pkg::ACT_FILL) pixel_value <= it2.word;
      else pixel_value <= {res[3], res[2], res[1], res[0]};
    end
  end
endmodule
`default_nettype wire

// File: src/oriented_quad_texture_shader.sv
// Oriented quad texture shader: one request per cycle sustained; every stage
// advances together and holds while the output result waits. Set-quad and
// texel-load requests give no result. Synchronous reset clears valid bits,
// quad registers to zero and both texture size registers to 64; the texture
// store is not cleared.
// Depends on oqts_pkg, oqts_geom, oqts_texdiv, oqts_shade.
`timescale 1ns / 1ps
`default_nettype none
module oriented_quad_texture_shader #(
  parameter int TEXEL_DEPTH = oqts_pkg::TEXEL_DEPTH_DEF,
  parameter int COORD_BITS  = oqts_pkg::COORD_BITS_DEF
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  // pixel_x, pixel_y, dest_pixel, origin_x, origin_y, xaxis_dx, xaxis_dy,
  // yaxis_dx, yaxis_dy, texel_index, texel_word, zero pad
  input  wire  [231:0] s_tdata,
  // action
  input  wire  [1:0]   s_tuser,
  output logic         m_tvalid,
  input  wire          m_tready,
  // out_x, out_y, pixel_value
  output logic [55:0]  m_tdata,
  // write_enable
  output logic         m_tuser,
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire          cfg_index,
  input  wire  [6:0]   cfg_data
);
  localparam int SW = oqts_pkg::SW;

  logic en;
  logic [6:0] reg_w, reg_h, w_c, h_c;
  logic [11:0] cmask;
  oqts_pkg::item_t in_item, g_item, t_item;
  logic signed [SW-1:0] dot_x, dot_y, len_x, len_y;
  logic [11:0] tex_index, out_x, out_y;
  logic [31:0] pixel_value;
  logic write_enable;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  assign cfg_ready = 1'b1;
  assign cmask = 12'((32'd1 << COORD_BITS) - 32'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_w <= 7'd64; reg_h <= 7'd64;
    end else if (cfg_valid) begin
      unique case (oqts_pkg::reg_index_t'(cfg_index))
        oqts_pkg::REG_TEX_W: reg_w <= cfg_data;
        oqts_pkg::REG_TEX_H: reg_h <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_c = (reg_w == 7'd0) ? 7'd1 : (reg_w > 7'd64) ? 7'd64 : reg_w;
    h_c = (reg_h == 7'd0) ? 7'd1 : (reg_h > 7'd64) ? 7'd64 : reg_h;
    in_item.valid   = s_tvalid && en;
    in_item.act     = oqts_pkg::action_t'(s_tuser);
    in_item.px      = s_tdata[11:0] & cmask;
    in_item.py      = s_tdata[23:12] & cmask;
    in_item.dest    = s_tdata[55:24];
    in_item.tidx    = s_tdata[193:182];
    in_item.word    = s_tdata[225:194];
    in_item.covered = 1'b0;
  end

  oqts_geom u_geom (
    .clk(clk), .rst(rst), .en(en), .in_item(in_item),
    .origin_x(s_tdata[76:56]), .origin_y(s_tdata[97:77]),
    .xaxis_dx(s_tdata[118:98]), .xaxis_dy(s_tdata[139:119]),
    .yaxis_dx(s_tdata[160:140]), .yaxis_dy(s_tdata[181:161]),
    .out_item(g_item), .dot_x(dot_x), .dot_y(dot_y), .len_x(len_x), .len_y(len_y)
  );

  oqts_texdiv u_texdiv (
    .clk(clk), .rst(rst), .en(en), .in_item(g_item),
    .dot_x(dot_x), .dot_y(dot_y), .len_x(len_x), .len_y(len_y),
    .tex_w(w_c), .tex_wm1(6'(w_c - 7'd1)), .tex_hm1(6'(h_c - 7'd1)),
    .out_item(t_item), .tex_index(tex_index)
  );

  oqts_shade #(.TEXEL_DEPTH(TEXEL_DEPTH)) u_shade (
    .clk(clk), .rst(rst), .en(en), .in_item(t_item), .tex_index(tex_index),
    .out_valid(m_tvalid), .out_x(out_x), .out_y(out_y),
    .write_enable(write_enable), .pixel_value(pixel_value)
  );

  assign m_tdata = {pixel_value, out_y, out_x};
  assign m_tuser = write_enable;
endmodule
`default_nettype wire
